// ----- rtl/assert_macros.svh -----
// Assertion macros used by the integer-to-text datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while in reset.
`define SIRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge, off while in reset.
`define SIRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sirt_pkg.sv -----
// Shared constants and controller/datapath interface types for the integer-to-text unit.
package sirt_pkg;

  // Number and symbol set dimensions
  localparam int NUMBER_BITS = 32;
  localparam int MAX_SYMBOLS = 16;
  localparam int SYM_SLOTS   = 16;
  localparam int SYM_IDX_W   = 4;
  localparam int DIGIT_W     = 4;
  localparam int CNT_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int SYM_VEC_W   = SYM_SLOTS * CHAR_W;

  // Digit stack holds one digit per magnitude bit at most (radix two)
  localparam int STK_DEPTH = NUMBER_BITS;
  localparam int DEPTH_W   = $clog2(STK_DEPTH + 1);
  localparam int BIT_W     = $clog2(NUMBER_BITS);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Special characters
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture number, clear counters
    logic chk_step;    // advance symbol check index
    logic div_step;    // one restoring division bit
    logic emit_sign;   // load '-' into output register
    logic emit_digit;  // pop one digit into output register
  } sirt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_ok;    // symbol count within 2..MAX_SYMBOLS
    logic chk_bad;     // current symbol is illegal or duplicated
    logic chk_last;    // current symbol is the last one in use
    logic div_last;    // current division step is the final bit
    logic quot_zero;   // quotient after this step is zero
    logic negative;    // captured number is negative
    logic one_left;    // one digit remains on the stack
    logic out_free;    // output register can take a character
  } sirt_sts_t;

endpackage

// ----- rtl/signed_integer_to_radix_text_unit.sv -----
// Top level of the signed integer to radix text unit.
//
//  Channel   Dir  Payload                         Handshake
//  s_axis    in   tdata[31:0] = number (signed)   tvalid/tready
//  m_axis    out  tdata[7:0] = character, tlast   tvalid/tready
//  cfg       in   cfg_data_i by cfg_idx_i         cfg_we_i
//
// One number at a time: an accept, a check of the symbols in use, a full-width
// pass of the shared bit-serial divider per digit, then one character at a time
// into the output register, which may still hold a character when the next
// number is accepted. An invalid symbol set ends the number with no output.
// Reset is asynchronous, active low; output stalls hold the unit.
module signed_integer_to_radix_text_unit
  import sirt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [NUMBER_BITS-1:0] s_axis_tdata,   // [31:0] number
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [CHAR_W-1:0]      m_axis_tdata,   // [7:0] character
  output logic                   m_axis_tlast
);

  sirt_cmd_t cmd;
  sirt_sts_t sts;

  sirt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sirt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .number_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- rtl/sirt_ctrl.sv -----
// Controller state machine: sequences symbol check, digit division and character output.
module sirt_ctrl
  import sirt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sirt_sts_t sts_i,
  output sirt_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts_i.count_ok || sts_i.chk_bad) begin
          state_d = ST_IDLE;
        end else if (sts_i.chk_last) begin
          state_d = ST_DIV;
        end else begin
          cmd_o.chk_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last && sts_i.quot_zero) begin
          state_d = sts_i.negative ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.one_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/sirt_dp.sv -----
// Datapath: symbol registers and check, bit-serial divider, digit stack, output register.
module sirt_dp
  import sirt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [NUMBER_BITS-1:0] number_i,
  input  sirt_cmd_t              cmd_i,
  output sirt_sts_t              sts_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   out_last_o
);

`include "assert_macros.svh"

  logic [CNT_W-1:0]       cnt_q;
  logic [SYM_VEC_W-1:0]   syms_q;
  logic [SYM_IDX_W-1:0]   chk_q;
  logic [CHAR_W-1:0]      cur_sym;
  logic                   dup;
  logic                   neg_q;
  logic [NUMBER_BITS-1:0] raw;
  logic [NUMBER_BITS-1:0] mag_q, mag_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [DIGIT_W:0]       trial;
  logic                   ge;
  logic [BIT_W-1:0]       bit_q;
  logic [DIGIT_W-1:0]     stk_q [STK_DEPTH];
  logic [DEPTH_W-1:0]     depth_q;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      out_char_q;
  logic                   out_last_q;

  function automatic logic [CHAR_W-1:0] sym_at(input logic [SYM_VEC_W-1:0] syms,
                                               input logic [SYM_IDX_W-1:0] idx);
    sym_at = syms[idx*CHAR_W +: CHAR_W];
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      syms_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYMBOL_COUNT: cnt_q <= cfg_data_i[CNT_W-1:0];
        REG_SYMBOLS_LOW:  syms_q[SYM_VEC_W/2-1:0] <= cfg_data_i;
        REG_SYMBOLS_HIGH: syms_q[SYM_VEC_W-1:SYM_VEC_W/2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Symbol check: one symbol per cycle against all later symbols in use
  always_comb begin
    cur_sym = sym_at(syms_q, chk_q);
    dup     = 1'b0;
    for (int b = 0; b < SYM_SLOTS; b++) begin
      if ((SYM_IDX_W'(b) > chk_q) && (CNT_W'(b) < cnt_q) &&
          (sym_at(syms_q, SYM_IDX_W'(b)) == cur_sym)) begin
        dup = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= '0;
    end else if (cmd_i.load) begin
      chk_q <= '0;
    end else if (cmd_i.chk_step) begin
      chk_q <= chk_q + 1'b1;
    end
  end

  // Restoring division by the radix, one quotient bit per cycle
  assign raw   = number_i;
  assign trial = {rem_q, mag_q[NUMBER_BITS-1]};
  assign ge    = trial >= cnt_q;
  assign rem_d = ge ? DIGIT_W'(trial - cnt_q) : trial[DIGIT_W-1:0];
  assign mag_d = {mag_q[NUMBER_BITS-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= raw[NUMBER_BITS-1];
      mag_q <= raw[NUMBER_BITS-1] ? (~raw + NUMBER_BITS'(1)) : raw;
    end else if (cmd_i.div_step) begin
      mag_q <= mag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.load) begin
      bit_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (sts_o.div_last) begin
        bit_q <= '0;
        rem_q <= '0;
      end else begin
        bit_q <= bit_q + 1'b1;
        rem_q <= rem_d;
      end
    end
  end

  // Digit stack: least significant digit pushed first, popped last
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && sts_o.div_last) begin
      stk_q[0] <= rem_d;
      for (int i = 1; i < STK_DEPTH; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (cmd_i.emit_digit) begin
      for (int i = 0; i < STK_DEPTH - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else if (cmd_i.load) begin
      depth_q <= '0;
    end else if (cmd_i.div_step && sts_o.div_last) begin
      depth_q <= depth_q + 1'b1;
    end else if (cmd_i.emit_digit) begin
      depth_q <= depth_q - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_char_q <= CHAR_MINUS;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_char_q <= sym_at(syms_q, stk_q[0]);
      out_last_q <= sts_o.one_left;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  // Status to controller
  always_comb begin
    sts_o           = '0;
    sts_o.count_ok  = (cnt_q >= CNT_W'(2)) && (cnt_q <= CNT_W'(MAX_SYMBOLS));
    sts_o.chk_bad   = (cur_sym == CHAR_NUL) || (cur_sym == CHAR_PLUS) ||
                      (cur_sym == CHAR_MINUS) || dup;
    sts_o.chk_last  = ({1'b0, chk_q} == (cnt_q - CNT_W'(1)));
    sts_o.div_last  = (bit_q == BIT_W'(NUMBER_BITS - 1));
    sts_o.quot_zero = (mag_d == '0);
    sts_o.negative  = neg_q;
    sts_o.one_left  = (depth_q == DEPTH_W'(1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  `SIRT_ASSERT(a_depth_bound, depth_q <= DEPTH_W'(STK_DEPTH), "digit stack overflow")
  `SIRT_ASSERT_IMP(a_emit_free, cmd_i.emit_sign || cmd_i.emit_digit, sts_o.out_free,
    "character emitted over a pending one")
  `SIRT_ASSERT_IMP(a_pop_nonempty, cmd_i.emit_digit, depth_q != '0, "pop from empty stack")
  `SIRT_ASSERT_IMP(a_rem_range, cmd_i.div_step, {1'b0, rem_q} < cnt_q,
    "partial remainder not below radix")

endmodule

// ----- tb/signed_integer_to_radix_text_unit_test.sv -----
// Testbench for the integer to radix text unit: random and directed numbers, checked per character.
module signed_integer_to_radix_text_unit_test;
  import sirt_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 4;
  // an accept, a full symbol check, a full-width division per binary digit, then output
  localparam int DRAIN_CYCLES = 1 + MAX_SYMBOLS + NUMBER_BITS * (NUMBER_BITS + 1) + 64;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int LONG_HOLD    = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 410;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // decimal digits, and junk in the unused slots that must be ignored
  localparam logic [CFG_DATA_W-1:0] DEC_LOW       = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] DEC_HIGH_JUNK = 64'h2B00_3000_2D2B_3938;
  localparam logic [CFG_DATA_W-1:0] HEX_HIGH      = 64'h6665_6463_6261_3938;

  typedef struct {
    logic [CHAR_W-1:0] symbol;
    logic              is_last;
  } text_char_t;

  // Holds the register copy and the characters still owed by the unit
  class radix_text_tracker;
    logic [CNT_W-1:0]     symbol_count;
    logic [SYM_VEC_W-1:0] symbols;
    text_char_t           expected_text[$];
    int                   errors;
    int                   chars_checked;
    int                   silent_numbers;

    function new();
      symbol_count   = '0;
      symbols        = '0;
      errors         = 0;
      chars_checked  = 0;
      silent_numbers = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SYMBOL_COUNT: symbol_count = data[CNT_W-1:0];
        REG_SYMBOLS_LOW:  symbols[CFG_DATA_W-1:0] = data;
        REG_SYMBOLS_HIGH: symbols[SYM_VEC_W-1:CFG_DATA_W] = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    // radix in range, no sign, no NUL, no repeats among the used symbols
    function bit set_usable();
      int unsigned       n, a, b;
      logic [CHAR_W-1:0] s;
      n = int'(unsigned'(symbol_count));
      if (n < 2 || n > MAX_SYMBOLS) return 1'b0;
      for (a = 0; a < n; a++) begin
        s = symbols[a*CHAR_W +: CHAR_W];
        if (s == CHAR_NUL || s == CHAR_PLUS || s == CHAR_MINUS) return 1'b0;
        for (b = a + 1; b < n; b++)
          if (symbols[b*CHAR_W +: CHAR_W] == s) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Accepted number: queue its sign and digits, most significant first
    function void note_number(logic [NUMBER_BITS-1:0] number);
      logic [NUMBER_BITS:0]   mag;
      logic [DIGIT_W-1:0]     digits[NUMBER_BITS];
      int                     nd, i;
      int unsigned            radix;
      logic                   negative;
      text_char_t             c;
      if (!set_usable()) begin
        silent_numbers++;
        return;
      end
      radix    = 32'(symbol_count);
      negative = number[NUMBER_BITS-1];
      // one extra bit keeps the most negative magnitude exact
      mag = negative ? ({1'b1, {NUMBER_BITS{1'b0}}} - {1'b0, number}) : {1'b0, number};
      nd  = 0;
      do begin
        digits[nd] = DIGIT_W'(mag % radix);
        mag        = mag / radix;
        nd++;
      end while (mag != 0);
      if (negative) begin
        c.symbol  = CHAR_MINUS;
        c.is_last = 1'b0;
        expected_text.push_back(c);
      end
      for (i = nd - 1; i >= 0; i--) begin
        c.symbol  = symbols[digits[i]*CHAR_W +: CHAR_W];
        c.is_last = (i == 0);
        expected_text.push_back(c);
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Output transaction: compare with the oldest owed character
    function void check_char(logic [CHAR_W-1:0] symbol, logic is_last);
      text_char_t want;
      chars_checked++;
      if (expected_text.size() == 0) begin
        flag($sformatf("unexpected character 0x%02h last=%0b", symbol, is_last));
        return;
      end
      want = expected_text.pop_front();
      if (symbol !== want.symbol)
        flag($sformatf("character: expected 0x%02h, got 0x%02h", want.symbol, symbol));
      if (is_last !== want.is_last)
        flag($sformatf("last flag: expected %0b, got %0b", want.is_last, is_last));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [NUMBER_BITS-1:0] s_axis_tdata;   // [31:0] number
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [CHAR_W-1:0]      m_axis_tdata;   // [7:0] character
  logic                   m_axis_tlast;

  radix_text_tracker tracker = new();

  int burst_left       = 0;
  int numbers_taken    = 0;
  int negatives_taken  = 0;
  int settings_applied = 0;
  int random_numbers   = 0;
  bit hold_request     = 1'b0;
  bit long_hold_done   = 1'b0;

  signed_integer_to_radix_text_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Transaction monitors on both streams
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tracker.note_number(s_axis_tdata);
      numbers_taken++;
      if (s_axis_tdata[NUMBER_BITS-1]) negatives_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_char(m_axis_tdata, m_axis_tlast);
  end

  // Receiver: segments of always ready, coin flips, a fixed pattern, or mostly stalled
  initial begin : receiver
    int mode, len, tick;
    tick = 0;
    m_axis_tready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 60);
      repeat (len) begin
        @(posedge clk_i);
        tick++;
        if (hold_request) begin
          // long hold-off while the sender keeps offering numbers
          m_axis_tready <= 1'b0;
          repeat (LONG_HOLD - 1) @(posedge clk_i);
          hold_request = 1'b0;
        end else begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (tick % 3 != 2);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

  // Offer one number; bursts of random length separated by random gaps
  task automatic offer_number(input logic [NUMBER_BITS-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering, wait for every owed character, then let a silent number finish
  task automatic settle_unit();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_register(idx, data);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] count_word,
                               input logic [CFG_DATA_W-1:0] low,
                               input logic [CFG_DATA_W-1:0] high,
                               input bit poke_unused);
    write_register(REG_SYMBOL_COUNT, count_word);
    write_register(REG_SYMBOLS_LOW, low);
    write_register(REG_SYMBOLS_HIGH, high);
    if (poke_unused) write_register(REG_UNUSED, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // Random symbol set: distinct legal symbols in use, junk beyond, sometimes a flaw
  task automatic random_setting(output logic [CFG_DATA_W-1:0] count_word,
                                output logic [SYM_VEC_W-1:0] sym_vec,
                                output bit flawed);
    bit                seen [256];
    logic [CHAR_W-1:0] b;
    int                radix, slot, a, k;
    for (slot = 0; slot < 256; slot++) seen[slot] = 1'b0;
    case ($urandom_range(0, 4))
      0:       radix = 2;
      1:       radix = MAX_SYMBOLS;
      default: radix = $urandom_range(2, MAX_SYMBOLS);
    endcase
    for (slot = 0; slot < SYM_SLOTS; slot++) begin
      if (slot < radix) begin
        do b = CHAR_W'($urandom_range(1, 255));
        while (b == CHAR_PLUS || b == CHAR_MINUS || seen[b]);
        seen[b] = 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0:       b = CHAR_NUL;
          1:       b = CHAR_PLUS;
          2:       b = CHAR_MINUS;
          3:       b = sym_vec[$urandom_range(0, radix - 1)*CHAR_W +: CHAR_W];
          default: b = CHAR_W'($urandom);
        endcase
      end
      sym_vec[slot*CHAR_W +: CHAR_W] = b;
    end
    flawed = ($urandom_range(0, 5) == 0);
    if (flawed) begin
      a = $urandom_range(0, radix - 1);
      case ($urandom_range(0, 5))
        0: radix = $urandom_range(0, 1);
        1: radix = $urandom_range(MAX_SYMBOLS + 1, 2**CNT_W - 1);
        2: sym_vec[a*CHAR_W +: CHAR_W] = CHAR_PLUS;
        3: sym_vec[a*CHAR_W +: CHAR_W] = CHAR_MINUS;
        4: sym_vec[a*CHAR_W +: CHAR_W] = CHAR_NUL;
        default: begin
          k = $urandom_range(0, radix - 1);
          if (k == a) k = (a + 1) % radix;
          sym_vec[k*CHAR_W +: CHAR_W] = sym_vec[a*CHAR_W +: CHAR_W];
        end
      endcase
    end
    count_word = {$urandom, $urandom};
    if ($urandom_range(0, 1)) count_word = '0;
    count_word[CNT_W-1:0] = radix[CNT_W-1:0];
  endtask

  function automatic logic [NUMBER_BITS-1:0] pick_number();
    logic [NUMBER_BITS-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      3: begin
        r = $urandom_range(0, 40);
        return $urandom_range(0, 1) ? -r : r;
      end
      4: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return 32'd1;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h7FFF_FFFF;
          4:       return 32'h8000_0000;
          default: return 32'h8000_0001;
        endcase
      end
      5:       return (32'd1 << $urandom_range(0, NUMBER_BITS - 1)) - $urandom_range(0, 1);
      6:       return {{16{r[15]}}, r[15:0]};
      7: begin
        r = $urandom_range(1, 1000000);
        return -r;
      end
      default: return r;
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] count_word;
    logic [SYM_VEC_W-1:0]  sym_vec;
    bit                    flawed;
    int                    len, k;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_SYMBOL_COUNT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: no symbols, so nothing comes out
    offer_number(32'd5);
    offer_number(-32'd5);
    settle_unit();

    // decimal, junk in the unused slots, then a write to the unused index
    apply_setting(64'd10, DEC_LOW, DEC_HIGH_JUNK, 1'b1);
    offer_number(32'd0);
    offer_number(32'd1);
    offer_number(32'hFFFF_FFFF);
    offer_number(32'h7FFF_FFFF);
    offer_number(32'h8000_0000);
    offer_number(32'd1000000000);
    offer_number(-32'd10);
    settle_unit();

    // radix 16, count written with all upper bits set
    apply_setting(64'hFFFF_FFFF_FFFF_FFF0, DEC_LOW, HEX_HIGH, 1'b0);
    offer_number(32'hDEAD_BEEF);
    offer_number(32'd16);
    offer_number(32'hFFFF_FFFF);
    offer_number(32'd0);
    settle_unit();

    // radix 2: most negative value gives the longest text
    apply_setting(64'd2, 64'h6261, 64'h0, 1'b0);
    offer_number(32'h8000_0000);
    offer_number(32'h7FFF_FFFF);
    offer_number(32'd0);
    offer_number(32'h5555_5555);
    settle_unit();

    // rejected sets: one symbol, count beyond the maximum, sign, NUL, repeat
    apply_setting(64'd1, DEC_LOW, DEC_HIGH_JUNK, 1'b0);
    offer_number(32'd123);
    settle_unit();
    apply_setting(64'hA5A5_0000_0000_0031, DEC_LOW, DEC_HIGH_JUNK, 1'b0);
    offer_number(-32'd123);
    settle_unit();
    apply_setting(64'd31, DEC_LOW, DEC_HIGH_JUNK, 1'b0);
    offer_number(32'd77);
    settle_unit();
    apply_setting(64'd10, 64'h3736_352B_3332_3130, DEC_HIGH_JUNK, 1'b0);
    offer_number(32'd55);
    settle_unit();
    apply_setting(64'd10, DEC_LOW, 64'h0000_0000_0000_2D38, 1'b0);
    offer_number(32'd9);
    settle_unit();
    apply_setting(64'd10, 64'h3736_3534_3332_3100, DEC_HIGH_JUNK, 1'b0);
    offer_number(-32'd9);
    settle_unit();
    apply_setting(64'd10, 64'h3336_3534_3332_3130, DEC_HIGH_JUNK, 1'b0);
    offer_number(32'd1000);
    settle_unit();

    // random symbol sets, each followed by a stream of random numbers
    while (random_numbers < RANDOM_ITEMS) begin
      random_setting(count_word, sym_vec, flawed);
      apply_setting(count_word, sym_vec[CFG_DATA_W-1:0], sym_vec[SYM_VEC_W-1:CFG_DATA_W],
                    $urandom_range(0, 3) == 0);
      len = flawed ? $urandom_range(2, 6) : $urandom_range(8, 40);
      for (k = 0; k < len; k++) begin
        offer_number(pick_number());
        if (!flawed) random_numbers++;
        if (!flawed && !long_hold_done && k == 2) begin
          hold_request   = 1'b1;
          long_hold_done = 1'b1;
        end
      end
      settle_unit();
    end

    $display("Run covered %0d numbers (%0d negative) over %0d symbol settings, %0d characters.",
             numbers_taken, negatives_taken, settings_applied, tracker.chars_checked);
    $display("%0d numbers met a rejected symbol set; one output hold of %0d cycles.",
             tracker.silent_numbers, LONG_HOLD);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
